/* design/mwm_pkg.sv */
// shared constants and types for the mecanum wheel mixer
`timescale 1ns / 1ps
package mwm_pkg;

  localparam int CMD_W   = 16;
  localparam int GEOM_W  = 12;
  localparam int LIMIT_W = 15;
  localparam int WHEELS  = 4;

  localparam logic REG_GEOMETRY = 1'b0;
  localparam logic REG_LIMIT    = 1'b1;

  localparam logic [GEOM_W-1:0]  GEOM_RESET  = GEOM_W'(256);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1000);

  typedef struct packed {
    logic              valid;
    logic              scale;
    logic [WHEELS-1:0] neg;
  } mwm_ctl_t;

endpackage

/* design/mwm_front.sv */
// kinematics front end: rotate scaling, wheel sums, peak search and scale products
`timescale 1ns / 1ps
module mwm_front #(
  parameter int K_FRAC_BITS = 8,
  parameter int KW = 21,
  parameter int WW = 24
) (
  input  logic                                                  clk,
  input  logic                                                  rst,
  input  logic                                                  start,
  input  logic signed [mwm_pkg::CMD_W-1:0]                      forward_cmd,
  input  logic signed [mwm_pkg::CMD_W-1:0]                      strafe_cmd,
  input  logic signed [mwm_pkg::CMD_W-1:0]                      rotate_cmd,
  input  logic [mwm_pkg::GEOM_W-1:0]                            geometry_factor,
  input  logic [mwm_pkg::LIMIT_W-1:0]                           speed_limit,
  output mwm_pkg::mwm_ctl_t                                     ctl,
  output logic [mwm_pkg::WHEELS-1:0][WW-1:0]                    rem,
  output logic [mwm_pkg::WHEELS-1:0][mwm_pkg::LIMIT_W-1:0]      num,
  output logic [WW-1:0]                                         mx,
  output logic [mwm_pkg::WHEELS-1:0][mwm_pkg::CMD_W-1:0]        pass
);
  import mwm_pkg::*;

  localparam int PW = CMD_W + GEOM_W;
  localparam logic [PW:0] HALF = (PW + 1)'(1) << (K_FRAC_BITS - 1);

  logic v1, v2, v3, v4, v5, v6;

  logic signed [CMD_W-1:0] f1, s1, f2, s2, f3, s3;
  logic [CMD_W-1:0]        rm1;
  logic                    rn1, rn2;
  logic [PW-1:0]           prod2;
  logic [PW:0]             rsum;
  logic [KW-1:0]           km;
  logic signed [WW-1:0]    kext;
  logic signed [WW-1:0]    k3;
  logic signed [WW-1:0]    fe, se;
  logic signed [WW-1:0]    w4 [WHEELS];
  logic [WW-1:0]           mag5 [WHEELS];
  logic [WW-1:0]           mag6 [WHEELS];
  logic [WHEELS-1:0]       neg5, neg6;
  logic [CMD_W-1:0]        pass5 [WHEELS];
  logic [CMD_W-1:0]        pass6 [WHEELS];
  logic [WW-1:0]           m01, m23, mx_next;
  logic [WW-1:0]           mx6;
  logic                    scale6;
  logic [WW+LIMIT_W-1:0]   prod7 [WHEELS];

  assign rsum = {1'b0, prod2} + HALF;
  assign km   = rsum[PW:K_FRAC_BITS];
  assign kext = WW'(km);
  assign fe   = WW'(f3);
  assign se   = WW'(s3);

  assign m01     = (mag5[0] > mag5[1]) ? mag5[0] : mag5[1];
  assign m23     = (mag5[2] > mag5[3]) ? mag5[2] : mag5[3];
  assign mx_next = (m01 > m23) ? m01 : m23;

  always_comb begin
    for (int i = 0; i < WHEELS; i++) begin
      prod7[i] = (WW + LIMIT_W)'(mag6[i]) * (WW + LIMIT_W)'(speed_limit);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      v6        <= 1'b0;
      ctl.valid <= 1'b0;
    end else begin
      v1        <= start;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      v5        <= v4;
      v6        <= v5;
      ctl.valid <= v6;
    end
    ctl.scale <= scale6;
    ctl.neg   <= neg6;
  end

  always_ff @(posedge clk) begin
    // magnitude of rotate, most negative pattern included
    f1  <= forward_cmd;
    s1  <= strafe_cmd;
    rn1 <= rotate_cmd[CMD_W-1];
    rm1 <= rotate_cmd[CMD_W-1] ? CMD_W'(-rotate_cmd) : CMD_W'(rotate_cmd);

    f2    <= f1;
    s2    <= s1;
    rn2   <= rn1;
    prod2 <= PW'(rm1) * PW'(geometry_factor);

    f3 <= f2;
    s3 <= s2;
    k3 <= rn2 ? -kext : kext;

    w4[0] <= fe + se + k3;
    w4[1] <= fe - se - k3;
    w4[2] <= fe - se + k3;
    w4[3] <= fe + se - k3;

    for (int i = 0; i < WHEELS; i++) begin
      neg5[i]  <= w4[i][WW-1];
      mag5[i]  <= w4[i][WW-1] ? WW'(-w4[i]) : WW'(w4[i]);
      pass5[i] <= w4[i][CMD_W-1:0];
    end

    mx6    <= mx_next;
    scale6 <= mx_next > WW'(speed_limit);
    neg6   <= neg5;
    for (int i = 0; i < WHEELS; i++) begin
      mag6[i]  <= mag5[i];
      pass6[i] <= pass5[i];
    end

    mx        <= mx6;
    for (int i = 0; i < WHEELS; i++) begin
      rem[i]  <= prod7[i][WW+LIMIT_W-1:LIMIT_W];
      num[i]  <= prod7[i][LIMIT_W-1:0];
      pass[i] <= pass6[i];
    end
  end

endmodule

/* design/mwm_div_cell.sv */
// one restoring division step for all four wheels
`timescale 1ns / 1ps
module mwm_div_cell #(
  parameter int WW  = 24,
  parameter int BIT = 0
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  mwm_pkg::mwm_ctl_t                                 ctl_in,
  input  logic [mwm_pkg::WHEELS-1:0][WW-1:0]                rem_in,
  input  logic [mwm_pkg::WHEELS-1:0][mwm_pkg::LIMIT_W-1:0]  num_in,
  input  logic [mwm_pkg::WHEELS-1:0][mwm_pkg::LIMIT_W-1:0]  q_in,
  input  logic [WW-1:0]                                     mx_in,
  input  logic [mwm_pkg::WHEELS-1:0][mwm_pkg::CMD_W-1:0]    pass_in,
  output mwm_pkg::mwm_ctl_t                                 ctl_out,
  output logic [mwm_pkg::WHEELS-1:0][WW-1:0]                rem_out,
  output logic [mwm_pkg::WHEELS-1:0][mwm_pkg::LIMIT_W-1:0]  num_out,
  output logic [mwm_pkg::WHEELS-1:0][mwm_pkg::LIMIT_W-1:0]  q_out,
  output logic [WW-1:0]                                     mx_out,
  output logic [mwm_pkg::WHEELS-1:0][mwm_pkg::CMD_W-1:0]    pass_out
);
  import mwm_pkg::*;

  logic [WW:0]                        trial [WHEELS];
  logic [WW:0]                        diff [WHEELS];
  logic [WHEELS-1:0]                  ge;
  logic [WHEELS-1:0][WW-1:0]          rem_next;
  logic [WHEELS-1:0][LIMIT_W-1:0]     q_next;

  always_comb begin
    for (int i = 0; i < WHEELS; i++) begin
      trial[i]    = {rem_in[i], num_in[i][BIT]};
      diff[i]     = trial[i] - {1'b0, mx_in};
      ge[i]       = trial[i] >= {1'b0, mx_in};
      rem_next[i] = ge[i] ? diff[i][WW-1:0] : trial[i][WW-1:0];
      q_next[i]   = q_in[i] | (LIMIT_W'(ge[i]) << BIT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl_in.valid;
    end
    ctl_out.scale <= ctl_in.scale;
    ctl_out.neg   <= ctl_in.neg;
  end

  always_ff @(posedge clk) begin
    rem_out       <= rem_next;
    num_out       <= num_in;
    q_out         <= q_next;
    mx_out        <= mx_in;
    pass_out      <= pass_in;
  end

endmodule

/* design/mecanum_wheel_mixer_top.sv */
// top level of the mecanum wheel mixer: config registers, front end, divider chain, result word
`timescale 1ns / 1ps
// A command word is taken on every clock edge at which start is high; busy stays low, so a new
// word may follow in every cycle. Each word gives one result word on the wheel ports, marked by
// done for one cycle, after it has passed the front end registers (rotate magnitude, rotate
// product, rounding, wheel sums, magnitudes, peak search, scale products), the fifteen
// division cells, one per quotient bit of the speed limit width, and the output register.
// The receiver cannot stall the result words. Config writes are always ready; the registers
// are read several stages into the front end, so write them only while no word is in flight.
module mecanum_wheel_mixer_top #(
  parameter int K_FRAC_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [mwm_pkg::CMD_W-1:0]  forward_cmd,
  input  logic signed [mwm_pkg::CMD_W-1:0]  strafe_cmd,
  input  logic signed [mwm_pkg::CMD_W-1:0]  rotate_cmd,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [mwm_pkg::LIMIT_W-1:0]       cfg_data,
  output logic                              done,
  output logic signed [mwm_pkg::CMD_W-1:0]  left_front,
  output logic signed [mwm_pkg::CMD_W-1:0]  right_front,
  output logic signed [mwm_pkg::CMD_W-1:0]  left_back,
  output logic signed [mwm_pkg::CMD_W-1:0]  right_back
);
  import mwm_pkg::*;

  localparam int PW = CMD_W + GEOM_W;
  localparam int KW = PW + 1 - K_FRAC_BITS;
  localparam int WW = ((KW > CMD_W + 1) ? KW : CMD_W + 1) + 2;

  logic [GEOM_W-1:0]  geometry_factor;
  logic [LIMIT_W-1:0] speed_limit;

  mwm_ctl_t                       ctl_c  [LIMIT_W+1];
  logic [WHEELS-1:0][WW-1:0]      rem_c  [LIMIT_W+1];
  logic [WHEELS-1:0][LIMIT_W-1:0] num_c  [LIMIT_W+1];
  logic [WHEELS-1:0][LIMIT_W-1:0] q_c    [LIMIT_W+1];
  logic [WW-1:0]                  mx_c   [LIMIT_W+1];
  logic [WHEELS-1:0][CMD_W-1:0]   pass_c [LIMIT_W+1];

  logic [CMD_W-1:0]               qext [WHEELS];
  logic [WHEELS-1:0][CMD_W-1:0]   wheel_next;

  // fully pipelined, never holds off a command word
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      geometry_factor <= GEOM_RESET;
      speed_limit     <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GEOMETRY: geometry_factor <= cfg_data[GEOM_W-1:0];
        REG_LIMIT:    speed_limit     <= cfg_data;
        default:      ;
      endcase
    end
  end

  mwm_front #(
    .K_FRAC_BITS(K_FRAC_BITS),
    .KW(KW),
    .WW(WW)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .start(start && !busy),
    .forward_cmd(forward_cmd),
    .strafe_cmd(strafe_cmd),
    .rotate_cmd(rotate_cmd),
    .geometry_factor(geometry_factor),
    .speed_limit(speed_limit),
    .ctl(ctl_c[0]),
    .rem(rem_c[0]),
    .num(num_c[0]),
    .mx(mx_c[0]),
    .pass(pass_c[0])
  );

  assign q_c[0] = '0;

  for (genvar j = 0; j < LIMIT_W; j++) begin : g_cell
    mwm_div_cell #(
      .WW(WW),
      .BIT(LIMIT_W - 1 - j)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .ctl_in(ctl_c[j]),
      .rem_in(rem_c[j]),
      .num_in(num_c[j]),
      .q_in(q_c[j]),
      .mx_in(mx_c[j]),
      .pass_in(pass_c[j]),
      .ctl_out(ctl_c[j+1]),
      .rem_out(rem_c[j+1]),
      .num_out(num_c[j+1]),
      .q_out(q_c[j+1]),
      .mx_out(mx_c[j+1]),
      .pass_out(pass_c[j+1])
    );
  end

  always_comb begin
    for (int i = 0; i < WHEELS; i++) begin
      qext[i] = CMD_W'(q_c[LIMIT_W][i]);
      if (ctl_c[LIMIT_W].scale) begin
        wheel_next[i] = ctl_c[LIMIT_W].neg[i] ? -qext[i] : qext[i];
      end else begin
        wheel_next[i] = pass_c[LIMIT_W][i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_c[LIMIT_W].valid;
    end
  end

  always_ff @(posedge clk) begin
    left_front  <= wheel_next[0];
    right_front <= wheel_next[1];
    left_back   <= wheel_next[2];
    right_back  <= wheel_next[3];
  end

endmodule
